// File: hw/rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: running sample statistics shared definitions
// Widths, register indexes, datapath op codes and the microcode program
// that sequences one timed sample through the shared multiplier and dividers.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

   // Field widths
   localparam int SAMPLE_W  = 32;
   localparam int LABEL_W   = 16;
   localparam int STAT_W    = 32;
   localparam int WIDE_W    = 64;
   localparam int WARM_W    = 10;
   localparam int TIMED_W   = 16;
   localparam int WIDX_W    = WARM_W + 1;
   localparam int CSR_W     = 16;
   localparam int RSP_DATA_W = LABEL_W + 4 * STAT_W + WIDE_W;

   // Register reset values
   localparam logic [WARM_W-1:0]  WARM_UP_RESET = WARM_W'(100);
   localparam logic [TIMED_W-1:0] TIMED_RESET   = TIMED_W'(1000);

   // Register indexes
   localparam logic CSR_WARM_UP = 1'b0;
   localparam logic CSR_TIMED   = 1'b1;

   // Divider: 64-bit dividend, 32-bit divisor, one quotient bit per step
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int LOOP_W     = $clog2(DIV_STEPS);

   // Microcode program counter
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] STEP_DIV = PC_W'(8);

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SMP_SQ,
      MUL_I_SQLO,
      MUL_I_SQHI,
      MUL_SUM_LL,
      MUL_SUM_LH,
      MUL_I_IM1
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SQ_ADD,
      ACC_LOAD,
      ACC_ADD_HI,
      ACC_SUB,
      ACC_SUB_X2
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_LOOP,
      SEQ_EMIT
   } seq_op_type;

   typedef struct packed {
      mul_op_type      mul_op;
      acc_op_type      acc_op;
      logic            div_load;
      logic            div_step;
      logic            loop_load;
      seq_op_type      seq_op;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // Control store. Numerator is built as i*sumsq - sum*sum modulo 2^64
   // from 32x32 partial products; both divisions then run side by side.
   function automatic ucode_word_type rom_word(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{mul_op: MUL_NONE, acc_op: ACC_NONE, div_load: 1'b0, div_step: 1'b0,
            loop_load: 1'b0, seq_op: SEQ_NEXT, target: '0};
      unique case (pc)
         PC_W'(0): w.mul_op = MUL_SMP_SQ;
         PC_W'(1): w.acc_op = ACC_SQ_ADD;
         PC_W'(2): w.mul_op = MUL_I_SQLO;
         PC_W'(3): begin
            w.mul_op = MUL_I_SQHI;
            w.acc_op = ACC_LOAD;
         end
         PC_W'(4): begin
            w.mul_op = MUL_SUM_LL;
            w.acc_op = ACC_ADD_HI;
         end
         PC_W'(5): begin
            w.mul_op = MUL_SUM_LH;
            w.acc_op = ACC_SUB;
         end
         PC_W'(6): begin
            w.mul_op = MUL_I_IM1;
            w.acc_op = ACC_SUB_X2;
         end
         PC_W'(7): begin
            w.div_load  = 1'b1;
            w.loop_load = 1'b1;
         end
         STEP_DIV: begin
            w.div_step = 1'b1;
            w.seq_op   = SEQ_LOOP;
            w.target   = STEP_DIV;
         end
         default: w.seq_op = SEQ_EMIT;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rss_div.sv
// ----------------------------------------------------------------------------
// rss_div: bit-serial restoring divider
// Unsigned 64 by 32 division, one quotient bit per step; the caller counts
// the steps. Quotient is valid after DIV_STEPS steps following a load.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_div (
   input  wire logic                               clock,
   input  wire rss_pkg::div_ctrl_type              ctrl,
   input  wire logic [rss_pkg::DIVIDEND_W-1:0]     dividend,
   input  wire logic [rss_pkg::DIVISOR_W-1:0]      divisor,
   output logic      [rss_pkg::DIVIDEND_W-1:0]     quotient
);

   logic [rss_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [rss_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [rss_pkg::DIVISOR_W-1:0]  dsr_ff;
   logic [rss_pkg::DIVISOR_W:0]    trial;
   logic [rss_pkg::DIVISOR_W+1:0]  diff;
   logic                           fits;

   // One restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[rss_pkg::DIVIDEND_W-1]};
      diff   = {1'b0, trial} - {2'b00, dsr_ff};
      fits   = ~diff[rss_pkg::DIVISOR_W+1];
      rem_in = fits ? diff[rss_pkg::DIVISOR_W-1:0] : trial[rss_pkg::DIVISOR_W-1:0];
      quo_in = {quo_ff[rss_pkg::DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (ctrl.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: hw/rtl/running_sample_statistics_top.sv
// A timed item holds the input until its microcode program, including the
// 64-step bit-serial divider loop, has run and its result is loaded into
// the output register; the next item is accepted in the cycle after that
// result is loaded. Warm-up items are taken one per cycle.
// Reset (synchronous, active high) clears all statistics and the experiment
// number and loads the registers with warm-up 100 and timed count 1000.
// ----------------------------------------------------------------------------
// running_sample_statistics_top: running mean, variance, minimum, maximum
// Microcoded sequencer over a shared 32x32 multiplier, a 64-bit accumulator
// and two bit-serial dividers (variance and average run side by side).
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // item in
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [rss_pkg::SAMPLE_W-1:0]       req_tdata,   // [31:0] sample
   // item out
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [15:0] label, [47:16] current, [79:48] average, [111:80] minimum,
   // [143:112] maximum, [207:144] variance
   output logic      [rss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                    rsp_tlast,   // last
   // register writes
   input  wire logic                               csr_we,
   input  wire logic                               csr_index,
   input  wire logic [rss_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int SW = rss_pkg::SAMPLE_W;
   localparam int WW = rss_pkg::WIDE_W;
   localparam int HW = rss_pkg::WIDE_W / 2;

   // configuration
   logic [rss_pkg::WARM_W-1:0]  warm_cnt_ff, warm_cnt_in;
   logic [rss_pkg::TIMED_W-1:0] timed_cnt_ff, timed_cnt_in;

   // experiment state
   logic [WW-1:0]               sum_ff, sum_in;
   logic [WW-1:0]               sumsq_ff, sumsq_in;
   logic [SW-1:0]               least_ff, least_in;
   logic [SW-1:0]               largest_ff, largest_in;
   logic [rss_pkg::TIMED_W-1:0] ti_ff, ti_in;
   logic [rss_pkg::WIDX_W-1:0]  wi_ff, wi_in;
   logic [rss_pkg::LABEL_W-1:0] exp_ff, exp_in;

   // sequencer
   logic                        busy_ff, busy_in;
   logic [rss_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [rss_pkg::LOOP_W-1:0]  loop_ff, loop_in;
   rss_pkg::ucode_word_type     cw;

   // datapath
   logic [SW-1:0]               smp_ff, smp_in;
   logic                        fin_ff, fin_in;
   logic [WW-1:0]               prod_ff, prod_in;
   logic [WW-1:0]               acc_ff, acc_in;
   logic [HW-1:0]               mul_a, mul_b;
   logic [SW-1:0]               smp;
   logic [rss_pkg::TIMED_W-1:0] ti_next;
   logic                        req_acc;
   logic                        rsp_free;

   // dividers
   rss_pkg::div_ctrl_type       div_ctrl;
   logic [WW-1:0]               quo_var, quo_avg;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rss_pkg::LABEL_W-1:0] rsp_label_ff, rsp_label_in;
   logic [SW-1:0]               rsp_cur_ff, rsp_cur_in;
   logic [rss_pkg::STAT_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [rss_pkg::STAT_W-1:0]  rsp_min_ff, rsp_min_in;
   logic [rss_pkg::STAT_W-1:0]  rsp_max_ff, rsp_max_in;
   logic [WW-1:0]               rsp_var_ff, rsp_var_in;
   logic                        rsp_last_ff, rsp_last_in;

   assign cw         = rss_pkg::rom_word(pc_ff);
   assign req_tready = ~busy_ff;
   assign req_acc    = req_tvalid & ~busy_ff;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign smp        = req_tdata[SW-1:0];
   assign ti_next    = ti_ff + rss_pkg::TIMED_W'(1);

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cw.mul_op)
         rss_pkg::MUL_SMP_SQ: begin
            mul_a = smp_ff;
            mul_b = smp_ff;
         end
         rss_pkg::MUL_I_SQLO: begin
            mul_a = HW'(ti_ff);
            mul_b = sumsq_ff[HW-1:0];
         end
         rss_pkg::MUL_I_SQHI: begin
            mul_a = HW'(ti_ff);
            mul_b = sumsq_ff[WW-1:HW];
         end
         rss_pkg::MUL_SUM_LL: begin
            mul_a = sum_ff[HW-1:0];
            mul_b = sum_ff[HW-1:0];
         end
         rss_pkg::MUL_SUM_LH: begin
            mul_a = sum_ff[HW-1:0];
            mul_b = sum_ff[WW-1:HW];
         end
         rss_pkg::MUL_I_IM1: begin
            mul_a = HW'(ti_ff);
            mul_b = HW'(ti_ff - rss_pkg::TIMED_W'(1));
         end
         default: ;
      endcase
   end

   // Next-state logic
   always_comb begin
      warm_cnt_in  = warm_cnt_ff;
      timed_cnt_in = timed_cnt_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      least_in     = least_ff;
      largest_in   = largest_ff;
      ti_in        = ti_ff;
      wi_in        = wi_ff;
      exp_in       = exp_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      loop_in      = loop_ff;
      smp_in       = smp_ff;
      fin_in       = fin_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_label_in = rsp_label_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_last_in  = rsp_last_ff;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            rss_pkg::CSR_WARM_UP: warm_cnt_in  = csr_wdata[rss_pkg::WARM_W-1:0];
            rss_pkg::CSR_TIMED:   timed_cnt_in = csr_wdata[rss_pkg::TIMED_W-1:0];
         endcase
      end

      // output register drains
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // accept: warm-up items finish here, timed items start the program
      if (req_acc) begin
         if (wi_ff <= {1'b0, warm_cnt_ff}) begin
            if (wi_ff == '0 || smp < least_ff) begin
               least_in = smp;
            end
            wi_in = wi_ff + rss_pkg::WIDX_W'(1);
         end else begin
            ti_in  = ti_next;
            sum_in = sum_ff + WW'(smp);
            if (smp > largest_ff) begin
               largest_in = smp;
            end
            if (smp < least_ff) begin
               least_in = smp;
            end
            smp_in  = smp;
            fin_in  = (ti_next >= timed_cnt_ff);
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end

      // microcode step
      if (busy_ff) begin
         if (cw.mul_op != rss_pkg::MUL_NONE) begin
            prod_in = WW'(mul_a) * WW'(mul_b);
         end

         case (cw.acc_op)
            rss_pkg::ACC_SQ_ADD: sumsq_in = sumsq_ff + prod_ff;
            rss_pkg::ACC_LOAD:   acc_in   = prod_ff;
            rss_pkg::ACC_ADD_HI: acc_in   = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
            rss_pkg::ACC_SUB:    acc_in   = acc_ff - prod_ff;
            // cross term 2*lo*hi shifted up by 32
            rss_pkg::ACC_SUB_X2: acc_in   = acc_ff - {prod_ff[HW-2:0], {(HW+1){1'b0}}};
            default: ;
         endcase

         if (cw.loop_load) begin
            loop_in = rss_pkg::LOOP_W'(rss_pkg::DIV_STEPS - 1);
         end

         unique case (cw.seq_op)
            rss_pkg::SEQ_NEXT: pc_in = pc_ff + rss_pkg::PC_W'(1);
            rss_pkg::SEQ_LOOP: begin
               if (loop_ff != '0) begin
                  loop_in = loop_ff - rss_pkg::LOOP_W'(1);
                  pc_in   = cw.target;
               end else begin
                  pc_in = pc_ff + rss_pkg::PC_W'(1);
               end
            end
            rss_pkg::SEQ_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_label_in = fin_ff ? exp_ff : ti_ff;
                  rsp_cur_in   = smp_ff;
                  rsp_avg_in   = (ti_ff == '0) ? '0 : quo_avg[rss_pkg::STAT_W-1:0];
                  rsp_min_in   = least_ff;
                  rsp_max_in   = largest_ff;
                  rsp_var_in   = (ti_ff >= rss_pkg::TIMED_W'(2)) ? quo_var : '0;
                  rsp_last_in  = fin_ff;
                  busy_in      = 1'b0;
                  // end of experiment: clear and advance
                  if (fin_ff) begin
                     sum_in     = '0;
                     sumsq_in   = '0;
                     least_in   = '0;
                     largest_in = '0;
                     ti_in      = '0;
                     wi_in      = '0;
                     exp_in     = exp_ff + rss_pkg::LABEL_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_cnt_ff  <= rss_pkg::WARM_UP_RESET;
         timed_cnt_ff <= rss_pkg::TIMED_RESET;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         least_ff     <= '0;
         largest_ff   <= '0;
         ti_ff        <= '0;
         wi_ff        <= '0;
         exp_ff       <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         warm_cnt_ff  <= warm_cnt_in;
         timed_cnt_ff <= timed_cnt_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         least_ff     <= least_in;
         largest_ff   <= largest_in;
         ti_ff        <= ti_in;
         wi_ff        <= wi_in;
         exp_ff       <= exp_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      loop_ff      <= loop_in;
      smp_ff       <= smp_in;
      fin_ff       <= fin_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_label_ff <= rsp_label_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_var_ff   <= rsp_var_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Dividers: variance numerator / i*(i-1), and running sum / i
   assign div_ctrl.load = busy_ff & cw.div_load;
   assign div_ctrl.step = busy_ff & cw.div_step;

   rss_div u_div_var (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (acc_ff),
      .divisor  (prod_ff[rss_pkg::DIVISOR_W-1:0]),
      .quotient (quo_var)
   );

   rss_div u_div_avg (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .dividend (sum_ff),
      .divisor  (rss_pkg::DIVISOR_W'(ti_ff)),
      .quotient (quo_avg)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_var_ff, rsp_max_ff, rsp_min_ff, rsp_avg_ff, rsp_cur_ff,
                        rsp_label_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker: port-level checks for running sample statistics
// Watches the top level's ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [rss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                               rsp_tlast
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Loading a result also frees the input side
   a_emit_frees_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded while input still blocked");

   // Maximum and minimum bracket the current sample
   a_min_max_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[143:112] >= rsp_tdata[47:16] &&
                     rsp_tdata[111:80] <= rsp_tdata[47:16])
      else $error("minimum or maximum out of order");

   // First timed sample of an experiment has zero variance
   a_first_var_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && rsp_tdata[15:0] == 16'd1 |-> rsp_tdata[207:144] == '0)
      else $error("nonzero variance on first timed sample");

endmodule

bind running_sample_statistics_top rss_checker u_rss_checker (.*);

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: running sample statistics
// Streams samples into the block, predicts each timed result (label, sample,
// average, minimum, maximum, variance, last) with an in-bench tracker and
// compares every result field by field. Both stream sides stall at random.
// Warm-up and timed counts are rewritten between runs, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One result item as seen on the output stream
   typedef struct {
      logic [15:0] label;
      logic [31:0] current;
      logic [31:0] average;
      logic [31:0] minimum;
      logic [31:0] maximum;
      logic [63:0] variance;
      logic        last;
   } stats_result_type;

   // Tracks experiment state and holds the statistics still to come out
   class statistics_tracker_type;
      bit [63:0]        sum_acc;
      bit [63:0]        square_acc;
      bit [31:0]        low_mark;
      bit [31:0]        high_mark;
      bit [15:0]        timed_seen;
      bit [10:0]        warm_seen;
      bit [15:0]        run_number;
      bit [9:0]         warm_limit;
      bit [15:0]        timed_limit;
      stats_result_type awaited_stats[$];
      int               mismatch_count;

      function void clear_run();
         sum_acc    = '0;
         square_acc = '0;
         low_mark   = '0;
         high_mark  = '0;
         timed_seen = '0;
         warm_seen  = '0;
      endfunction

      function void restore_defaults();
         warm_limit  = rss_pkg::WARM_UP_RESET;
         timed_limit = rss_pkg::TIMED_RESET;
         clear_run();
         run_number = '0;
      endfunction

      function void set_register(logic idx, bit [15:0] value);
         if (idx == rss_pkg::CSR_WARM_UP) begin
            warm_limit = value[9:0];
         end else begin
            timed_limit = value;
         end
      endfunction

      // Accepted sample: update state, queue the result it causes
      function void absorb_sample(bit [31:0] s);
         bit [63:0]        w;
         bit [63:0]        i;
         bit [63:0]        spread;
         bit [63:0]        quot;
         bit               fin;
         stats_result_type r;
         // warm-up: minimum only, first sample loads it
         if (warm_seen <= {1'b0, warm_limit}) begin
            if (warm_seen == 11'd0 || s < low_mark) begin
               low_mark = s;
            end
            warm_seen = warm_seen + 11'd1;
            return;
         end
         timed_seen = timed_seen + 16'd1;
         i          = {48'd0, timed_seen};
         w          = {32'd0, s};
         sum_acc    = sum_acc + w;
         square_acc = square_acc + w * w;
         if (s > high_mark) begin
            high_mark = s;
         end
         if (s < low_mark) begin
            low_mark = s;
         end
         spread = '0;
         if (i >= 64'd2) begin
            spread = (i * square_acc - sum_acc * sum_acc) / (i * (i - 64'd1));
         end
         quot = (i != 64'd0) ? sum_acc / i : 64'd0;
         fin  = (i >= {48'd0, timed_limit});
         r.label    = fin ? run_number : i[15:0];
         r.current  = s;
         r.average  = quot[31:0];
         r.minimum  = low_mark;
         r.maximum  = high_mark;
         r.variance = spread;
         r.last     = fin;
         awaited_stats.push_back(r);
         if (fin) begin
            clear_run();
            run_number = run_number + 16'd1;
         end
      endfunction

      function void check_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      // Output item: compare with the oldest prediction
      function void compare_result(stats_result_type got);
         stats_result_type want;
         if (awaited_stats.size() == 0) begin
            $error("result with no prediction pending, label %0d", got.label);
            mismatch_count++;
            return;
         end
         want = awaited_stats.pop_front();
         check_field("label", want.label, got.label);
         check_field("current", want.current, got.current);
         check_field("average", want.average, got.average);
         check_field("minimum", want.minimum, got.minimum);
         check_field("maximum", want.maximum, got.maximum);
         check_field("variance", want.variance, got.variance);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [rss_pkg::SAMPLE_W-1:0]      req_tdata = '0;    // [31:0] sample
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // [15:0] label, [47:16] current, [79:48] average, [111:80] minimum,
   // [143:112] maximum, [207:144] variance
   logic [rss_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              rsp_tlast;          // last
   logic                              csr_we = 1'b0;
   logic                              csr_index = rss_pkg::CSR_WARM_UP;
   logic [rss_pkg::CSR_W-1:0]         csr_wdata = '0;

   statistics_tracker_type tracker;
   int send_idle_pct = 22;
   int recv_idle_pct = 79;

   running_sample_statistics_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure, one decision per cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      stats_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.label    = rsp_tdata[15:0];
         got.current  = rsp_tdata[47:16];
         got.average  = rsp_tdata[79:48];
         got.minimum  = rsp_tdata[111:80];
         got.maximum  = rsp_tdata[143:112];
         got.variance = rsp_tdata[207:144];
         got.last     = rsp_tlast;
         tracker.compare_result(got);
      end
   end

   // Present one sample, idling at random first; returns once accepted
   task automatic send_sample(input bit [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.absorb_sample(value);
   endtask

   // Drain: stop sending, wait for every result, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.awaited_stats.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input bit [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   function automatic bit [31:0] pick_sample();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(255);
         3:       return 32'hFFFF_FFFF - $urandom_range(255);
         default: return $urandom();
      endcase
   endfunction

   // Main sequence
   initial begin
      int        sent;
      int        burst;
      bit [9:0]  warm_pick;
      bit [15:0] timed_pick;
      tracker = new();
      tracker.restore_defaults();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extreme samples, no warm-up beyond the first; upper bits must be masked
      write_register(rss_pkg::CSR_WARM_UP, 16'hFC00);
      write_register(rss_pkg::CSR_TIMED, 16'd3);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'd0);
      send_sample(32'hFFFF_FFFF);
      wait_idle();

      // Timed count of zero ends on the first timed sample
      write_register(rss_pkg::CSR_WARM_UP, 16'd1);
      write_register(rss_pkg::CSR_TIMED, 16'd0);
      send_sample(32'd5);
      send_sample(32'd7);
      send_sample(32'h8000_0000);
      wait_idle();

      // Timed limit lowered below the running count mid-experiment
      write_register(rss_pkg::CSR_WARM_UP, 16'd2);
      write_register(rss_pkg::CSR_TIMED, 16'hFFFF);
      repeat (7) send_sample(pick_sample());
      wait_idle();
      write_register(rss_pkg::CSR_TIMED, 16'd2);
      send_sample(32'd12345);
      wait_idle();

      // Warm-up limit lowered mid warm-up
      write_register(rss_pkg::CSR_WARM_UP, 16'd1023);
      repeat (3) send_sample(pick_sample());
      wait_idle();
      write_register(rss_pkg::CSR_WARM_UP, 16'd0);
      send_sample(32'd1);
      send_sample(32'hFFFF_FFFE);
      wait_idle();

      // Random runs under three stall patterns
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < 260) begin
            case ($urandom_range(19))
               0:       warm_pick = 10'd1023;
               1:       warm_pick = 10'($urandom_range(1023));
               default: warm_pick = 10'($urandom_range(4));
            endcase
            case ($urandom_range(19))
               0:       timed_pick = 16'd0;
               1:       timed_pick = 16'hFFFF;
               2:       timed_pick = 16'($urandom_range(65535));
               default: timed_pick = 16'($urandom_range(1, 12));
            endcase
            // sometimes keep one register as is to carry state across
            if ($urandom_range(3) != 0) begin
               write_register(rss_pkg::CSR_WARM_UP, {6'($urandom()), warm_pick});
            end
            if ($urandom_range(3) != 0) begin
               write_register(rss_pkg::CSR_TIMED, timed_pick);
            end
            burst = $urandom_range(10, 50);
            if (burst > 260 - sent) begin
               burst = 260 - sent;
            end
            for (int k = 0; k < burst; k++) begin
               send_sample(pick_sample());
               sent++;
            end
            wait_idle();
         end
      end

      wait_idle();
      if (tracker.mismatch_count == 0 && tracker.awaited_stats.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("testbench: errors");
      $finish;
   end

endmodule

`default_nettype wire
